// File: rtl/lift_gamma_gain_grade_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the lift/gamma/gain grading block
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LIFT_GAMMA_GAIN_GRADE_MACROS_SVH
`define LIFT_GAMMA_GAIN_GRADE_MACROS_SVH

// Same-cycle implication.
`define LGGG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LGGG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lggg_pkg.sv
// ----------------------------------------------------------------------------
// Lift/gamma/gain grading package
// Fixed widths, pipeline depths and the log2/exp2 interpolation tables.
// ----------------------------------------------------------------------------
package lggg_pkg;

  localparam int unsigned SAMPLE_W  = 8;
  localparam int unsigned COEF_W    = 16;
  localparam int unsigned NUM_LANES = 3;
  localparam int unsigned PIX_W     = 4 * SAMPLE_W;
  localparam int unsigned CFG_W     = NUM_LANES * COEF_W;

  // Quotient bits of the exponent divider, one per stage.
  localparam int unsigned DIV_BITS  = 33;
  // Registers from lane input to lane output.
  localparam int unsigned LANE_LAT  = 13 + DIV_BITS;

  // Gamma at or below this code (gamma*1000 <= 1.0) uses exponent 1000.
  localparam logic [15:0] GAMMA_TINY_MAX = 16'd4;
  localparam logic [15:0] COEF_ONE       = 16'd4096;

  typedef enum logic [1:0] {
    REG_LIFT     = 2'd0,
    REG_GAMMA    = 2'd1,
    REG_GAIN     = 2'd2,
    REG_CHANNELS = 2'd3
  } reg_idx_e;

  localparam logic [16:0] LOG_TAB [17] = '{
    17'd0,     17'd5732,  17'd11136, 17'd16248, 17'd21098, 17'd25711,
    17'd30109, 17'd34312, 17'd38336, 17'd42196, 17'd45904, 17'd49472,
    17'd52911, 17'd56229, 17'd59434, 17'd62534, 17'd65536
  };

  localparam logic [17:0] EXP_TAB [17] = '{
    18'd65536,  18'd68438,  18'd71468,  18'd74632,  18'd77936,  18'd81386,
    18'd84989,  18'd88752,  18'd92682,  18'd96785,  18'd101070, 18'd105545,
    18'd110218, 18'd115098, 18'd120194, 18'd125515, 18'd131072
  };

endpackage

// File: rtl/lift_gamma_gain_grade.sv
// ----------------------------------------------------------------------------
// Lift/gamma/gain color grading
// Grades one RGBA pixel per beat with three parallel channel lanes.
//
//   Channel   Dir  Contents
//   s_axis    in   pixel beat: red, green, blue, alpha (8 bits each)
//   m_axis    out  graded pixel beat, same layout
//   cfg       in   register writes: lift, gamma, gain, channel count
//
// One beat is accepted per clock when the output side keeps up. Each beat
// passes from input to output through the 33-stage exponent divider in
// every lane plus the log2, exp2, gain and rescale stages.
// A stall on m_axis freezes the whole pipeline and drops s_axis_tready.
// Reset is asynchronous, active low; it empties the pipeline and loads
// lift 0, gamma 1.0, gain 1.0 and three graded channels.
// ----------------------------------------------------------------------------
`include "lift_gamma_gain_grade_macros.svh"

module lift_gamma_gain_grade (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // red [7:0], green [15:8], blue [23:16], alpha [31:24]
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // red [7:0], green [15:8], blue [23:16], alpha [31:24]
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [47:0] cfg_data_i
);

  localparam int unsigned LL  = lggg_pkg::LANE_LAT;
  localparam int unsigned LAT = LL + 1;

  logic [47:0] lift_q, gamma_q, gain_q;
  logic [2:0]  chans_q;
  logic [LAT-1:0] vld_q;
  logic [31:0] raw_q [LL];
  logic [31:0] out_q;
  logic [7:0]  lane_y [lggg_pkg::NUM_LANES];
  logic [1:0]  used;
  logic        en;

  // Configuration: plain writes, the channel count keeps its low three bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lift_q  <= '0;
      gamma_q <= {3{lggg_pkg::COEF_ONE}};
      gain_q  <= {3{lggg_pkg::COEF_ONE}};
      chans_q <= 3'd3;
    end else if (cfg_we_i) begin
      unique case (lggg_pkg::reg_idx_e'(cfg_idx_i))
        lggg_pkg::REG_LIFT:     lift_q  <= cfg_data_i;
        lggg_pkg::REG_GAMMA:    gamma_q <= cfg_data_i;
        lggg_pkg::REG_GAIN:     gain_q  <= cfg_data_i;
        lggg_pkg::REG_CHANNELS: chans_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline advances together unless the output beat is held.
  assign en            = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  // Raw pixel delay line, for ungraded channels and alpha.
  always_ff @(posedge clk_i) begin
    if (en) begin
      raw_q[0] <= s_axis_tdata;
      for (int i = 1; i < LL; i++) begin
        raw_q[i] <= raw_q[i-1];
      end
    end
  end

  for (genvar c = 0; c < lggg_pkg::NUM_LANES; c++) begin : g_lane
    lggg_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (en),
      .x_i     (s_axis_tdata[8*c +: 8]),
      .lift_i  (lift_q[16*c +: 16]),
      .gamma_i (gamma_q[16*c +: 16]),
      .gain_i  (gain_q[16*c +: 16]),
      .y_o     (lane_y[c])
    );
  end

  // Merge: graded lanes below the channel count, raw samples at or above it.
  assign used = (chans_q > 3'd3) ? 2'd3 : chans_q[1:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        out_q[8*c +: 8] <= (2'(c) < used) ? lane_y[c] : raw_q[LL-1][8*c +: 8];
      end
      out_q[31:24] <= raw_q[LL-1][31:24];
    end
  end

  assign m_axis_tdata = out_q;

  `LGGG_ASSERT_IMP(a_stall_blocks_input, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "stall did not reach input")
  `LGGG_ASSERT_NXT(a_accept_enters, s_axis_tvalid && s_axis_tready, vld_q[0], "accepted beat lost at entry")
  `LGGG_ASSERT_NXT(a_drain, m_axis_tvalid && m_axis_tready && !vld_q[LAT-2], !m_axis_tvalid, "beat repeated at output")

endmodule

// File: rtl/lggg_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage; carries a side payload along with the operands.
// ----------------------------------------------------------------------------
module lggg_div #(
  parameter int unsigned PW = 44
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [lggg_pkg::DIV_BITS-1:0] num_i,
  input  logic [15:0]                   den_i,
  input  logic [PW-1:0]                 pay_i,
  output logic [lggg_pkg::DIV_BITS-1:0] quo_o,
  output logic [PW-1:0]                 pay_o
);

  localparam int unsigned NB = lggg_pkg::DIV_BITS;

  logic [15:0]   rem_q [NB];
  logic [NB-1:0] num_q [NB];
  logic [NB-1:0] quo_q [NB];
  logic [PW-1:0] pay_q [NB];

  for (genvar j = 0; j < NB; j++) begin : g_stage
    logic [15:0]   rem_in;
    logic [NB-1:0] num_in;
    logic [NB-1:0] quo_in;
    logic [PW-1:0] pay_in;
    logic [16:0]   trial;
    logic          ge;

    if (j == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num_i;
      assign quo_in = '0;
      assign pay_in = pay_i;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign num_in = num_q[j-1];
      assign quo_in = quo_q[j-1];
      assign pay_in = pay_q[j-1];
    end

    assign trial = {rem_in, num_in[NB-1-j]};
    assign ge    = trial >= {1'b0, den_i};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= ge ? 16'(trial - {1'b0, den_i}) : trial[15:0];
        num_q[j] <= num_in;
        quo_q[j] <= quo_in | (NB'(ge) << (NB - 1 - j));
        pay_q[j] <= pay_in;
      end
    end
  end

  assign quo_o = quo_q[NB-1];
  assign pay_o = pay_q[NB-1];

endmodule

// File: rtl/lggg_lane.sv
// ----------------------------------------------------------------------------
// Grading lane
// Normalize, lift, power by log2/divide/exp2, gain, clamp and rescale.
// ----------------------------------------------------------------------------
module lggg_lane (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [7:0]  x_i,
  input  logic [15:0] lift_i,
  input  logic [15:0] gamma_i,
  input  logic [15:0] gain_i,
  output logic [7:0]  y_o
);

  localparam int unsigned NB = lggg_pkg::DIV_BITS;

  // Stage 1: x/255 in Q16, which is x*257 plus one when x >= 128.
  logic [16:0] v1_q;
  // Stage 2: lift * (1 - v).
  logic [16:0] v2_q;
  logic signed [33:0] prod2_q;
  // Stage 3: w, floored at zero.
  logic [19:0] w3_q;
  // Stage 4: leading one.
  logic [19:0] w4_q;
  logic [4:0]  k4_q;
  // Stage 5: log2 table lookup and interpolation product.
  logic [19:0] w5_q;
  logic [4:0]  k5_q;
  logic [16:0] lt5_q;
  logic [24:0] pr5_q;
  // Stage 6: log2(w) in Q16.
  logic [19:0] w6_q;
  logic signed [22:0] l6_q;
  // Stage 7: divider operands.
  logic [NB-1:0] num7_q;
  logic [43:0]   pay7_q;
  // Divider outputs.
  logic [NB-1:0] quo;
  logic [43:0]   pay;
  // Stages 41 to 46.
  logic signed [34:0] y_q;
  logic [19:0] wa_q, wb_q, wc_q;
  logic        hi_q, lo_q, hib_q, lob_q;
  logic [4:0]  e_q, eb_q;
  logic [17:0] et_q;
  logic [24:0] pre_q;
  logic [17:0] mant_q;
  logic [28:0] p_q;
  logic [44:0] qg_q;
  logic [7:0]  y_q8;

  // Combinational helpers.
  logic signed [34:0] prod_ext, sh_full;
  logic signed [21:0] wsum;
  logic [4:0]  k_d;
  logic [35:0] mfull;
  logic [15:0] mfrac;
  logic [4:0]  li;
  logic [13:0] lfrac;
  logic signed [6:0] kd;
  logic signed [20:0] lmag_s;
  logic [20:0] lmag;
  logic signed [34:0] y_d;
  logic [20:0] yo;
  logic [4:0]  xi;
  logic [4:0]  sh_r;
  logic [18:0] rnd;
  logic [28:0] p_d;
  logic [28:0] qc;
  logic [36:0] scaled;

  always_comb begin
    prod_ext = 35'(prod2_q);
    if (!prod2_q[33]) begin
      sh_full = (prod_ext + 35'sd2048) >>> 12;
    end else begin
      sh_full = -((-prod_ext + 35'sd2048) >>> 12);
    end
    wsum = $signed({5'b0, v2_q}) + 22'(sh_full);

    k_d = '0;
    for (int b = 1; b < 20; b++) begin
      if (w3_q[b]) k_d = 5'(b);
    end

    mfull = ({16'b0, w4_q} << 16) >> k4_q;
    mfrac = mfull[15:0];
    li    = {1'b0, mfrac[15:12]};

    kd     = $signed({2'b0, k5_q}) - 7'sd16;
    lfrac  = 14'((26'(pr5_q) + 26'd2048) >> 12);

    lmag_s = l6_q[22] ? 21'(-l6_q) : 21'(l6_q);
    lmag   = lmag_s;

    if (gamma_i <= lggg_pkg::GAMMA_TINY_MAX) begin
      y_d = 35'($signed(pay[43:21]) * 35'sd1000);
    end else if (pay[43]) begin
      y_d = -$signed({2'b0, quo});
    end else begin
      y_d = $signed({2'b0, quo});
    end

    yo = 21'(y_q + 35'sd1114112);
    xi = {1'b0, yo[15:12]};

    sh_r = 5'd17 - eb_q;
    rnd  = 19'(mant_q) + (19'd1 << (sh_r - 5'd1));
    if (hib_q) begin
      p_d = 29'd268435456;
    end else if (lob_q) begin
      p_d = '0;
    end else if (eb_q >= 5'd17) begin
      p_d = 29'({11'b0, mant_q} << (eb_q - 5'd17));
    end else begin
      p_d = 29'(rnd >> sh_r);
    end
    if (wc_q == '0) begin
      p_d = '0;
    end else if (gamma_i == lggg_pkg::COEF_ONE) begin
      p_d = 29'(wc_q);
    end

    qc     = (qg_q > 45'd268435456) ? 29'd268435456 : qg_q[28:0];
    scaled = ({8'b0, qc} << 8) - 37'(qc) + 37'd134217728;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v1_q    <= 17'({x_i, x_i}) + 17'(x_i[7]);
      v2_q    <= v1_q;
      prod2_q <= 34'($signed(lift_i) * $signed({1'b0, 17'(17'd65536 - v1_q)}));
      w3_q    <= wsum[21] ? 20'd0 : wsum[19:0];
      w4_q    <= w3_q;
      k4_q    <= k_d;
      w5_q    <= w4_q;
      k5_q    <= k4_q;
      lt5_q   <= lggg_pkg::LOG_TAB[li];
      pr5_q   <= 25'(13'(lggg_pkg::LOG_TAB[li + 5'd1] - lggg_pkg::LOG_TAB[li])
                     * mfrac[11:0]);
      w6_q    <= w5_q;
      l6_q    <= ($signed({{16{kd[6]}}, kd}) <<< 16) + $signed({6'b0, lt5_q})
                 + $signed({9'b0, lfrac});
      num7_q  <= ({12'b0, lmag} << 12) + NB'(gamma_i >> 1);
      pay7_q  <= {l6_q, 1'b0, w6_q};
      y_q     <= y_d;
      wa_q    <= pay[19:0];
      hi_q    <= y_q >= 35'sd786432;
      lo_q    <= y_q < -35'sd1114112;
      e_q     <= yo[20:16];
      et_q    <= lggg_pkg::EXP_TAB[xi];
      pre_q   <= 25'(13'(lggg_pkg::EXP_TAB[xi + 5'd1] - lggg_pkg::EXP_TAB[xi])
                     * yo[11:0]);
      wb_q    <= wa_q;
      mant_q  <= et_q + 18'((26'(pre_q) + 26'd2048) >> 12);
      eb_q    <= e_q;
      hib_q   <= hi_q;
      lob_q   <= lo_q;
      wc_q    <= wb_q;
      p_q     <= p_d;
      qg_q    <= 45'(p_q) * 45'(gain_i);
      y_q8    <= scaled[35:28];
    end
  end

  lggg_div #(
    .PW (44)
  ) u_div (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i (num7_q),
    .den_i (gamma_i),
    .pay_i (pay7_q),
    .quo_o (quo),
    .pay_o (pay)
  );

  assign y_o = y_q8;

endmodule

// File: tb/lift_gamma_gain_grade_test.sv
// ----------------------------------------------------------------------------
// Testbench for the lift/gamma/gain color grading block
// Drives pixel beats through the stream input under several register
// settings and idle patterns, predicts each graded pixel in fixed point and
// compares every output beat, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lift_gamma_gain_grade_test;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // red [7:0], green [15:8], blue [23:16], alpha [31:24]
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // red [7:0], green [15:8], blue [23:16], alpha [31:24]
  logic [31:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = lggg_pkg::REG_LIFT;
  logic [47:0] cfg_data_i = '0;

  lift_gamma_gain_grade DUT (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_idx_i,
    .cfg_data_i
  );

  localparam int unsigned CYCLE_LIMIT = 400000;

  // Shadow copy of the block's registers.
  logic [47:0] lift_regs, gamma_regs, gain_regs;
  logic [2:0]  chan_count;

  pixel_t graded_q[$];
  int unsigned mismatch_count;
  int unsigned beats_checked;
  int unsigned cycle_count;
  int unsigned send_idle_pct, recv_idle_pct;
  int unsigned hold_cycles;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Fixed-point predictor of one graded channel.
  // ---------------------------------------------------------------------------
  function automatic longint unsigned table_interp(input bit use_exp,
                                                   input longint unsigned frac);
    longint unsigned idx, rem, lo, hi;
    idx = (frac >> 12) & 15;
    rem = frac & 12'hFFF;
    lo = use_exp ? lggg_pkg::EXP_TAB[idx] : lggg_pkg::LOG_TAB[idx];
    hi = use_exp ? lggg_pkg::EXP_TAB[idx + 1] : lggg_pkg::LOG_TAB[idx + 1];
    return lo + (((hi - lo) * rem + 2048) >> 12);
  endfunction

  function automatic longint unsigned power_q16(input longint unsigned w,
                                                input longint unsigned g);
    int k;
    longint unsigned mant, mag, ym, yo, m;
    longint lg, y, n;
    k = 0;
    while (k < 62 && (w >> (k + 1)) != 0) k++;
    m = (k >= 16) ? (w >> (k - 16)) : (w << (16 - k));
    lg = longint'(k - 16) * 65536 + longint'(table_interp(1'b0, m - 65536));
    if (g * 1000 > lggg_pkg::COEF_ONE) begin
      mag = (lg < 0) ? longint'(-lg) : lg;
      ym = ((mag << 12) + g / 2) / g;
      y = (lg < 0) ? -longint'(ym) : longint'(ym);
    end else begin
      // Gamma at or below a thousandth uses a fixed exponent of 1000.
      y = lg * 1000;
    end
    if (y >= 12 * 65536) return 64'd1 << 28;
    if (y < -17 * 65536) return 0;
    yo = y + 17 * 65536;
    n = longint'(yo >> 16) - 17;
    mant = table_interp(1'b1, yo & 16'hFFFF);
    if (n >= 0) return mant << n;
    return (mant + (64'd1 << (-n - 1))) >> (-n);
  endfunction

  function automatic logic [7:0] graded_sample(input logic [7:0] x,
      input logic [15:0] lf, input logic [15:0] gm, input logic [15:0] gn);
    longint v, lift, prod, w;
    longint unsigned p, q;
    v = ((longint'(x) << 16) + 127) / 255;
    lift = longint'($signed(lf));
    prod = lift * (65536 - v);
    if (prod >= 0) w = v + ((prod + 2048) >>> 12);
    else w = v - ((-prod + 2048) >>> 12);
    if (w < 0) w = 0;
    if (w == 0) p = 0;
    else if (gm == lggg_pkg::COEF_ONE) p = w;
    else p = power_q16(w, gm);
    q = p * gn;
    if (q > (64'd1 << 28)) q = 64'd1 << 28;
    return 8'((q * 255 + (64'd1 << 27)) >> 28);
  endfunction

  function automatic pixel_t graded_pixel(input pixel_t px);
    pixel_t res;
    int unsigned used;
    logic [7:0] smp;
    used = (chan_count > 3) ? 3 : chan_count;
    res = px;
    for (int c = 0; c < 3; c++) begin
      smp = px[8*c +: 8];
      if (c < used)
        res[8*c +: 8] = graded_sample(smp, lift_regs[16*c +: 16],
                                      gamma_regs[16*c +: 16], gain_regs[16*c +: 16]);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random stalls, one long hold-off on request, and checking.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    $display("Mismatch at beat %0d: %s got %0d, wanted %0d",
             beats_checked, what, got, want);
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    pixel_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (graded_q.size() == 0) begin
        report_mismatch("unexpected beat", got, 0);
      end else begin
        want = graded_q.pop_front();
        if (got.red !== want.red) report_mismatch("red", got.red, want.red);
        if (got.green !== want.green) report_mismatch("green", got.green, want.green);
        if (got.blue !== want.blue) report_mismatch("blue", got.blue, want.blue);
        if (got.alpha !== want.alpha) report_mismatch("alpha", got.alpha, want.alpha);
      end
      beats_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side helpers.
  // ---------------------------------------------------------------------------
  task automatic send_pixel(input pixel_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= px;
    // Predict at the handshake so the register shadow matches the block.
    do @(posedge clk_i); while (!s_axis_tready);
    graded_q.push_back(graded_pixel(px));
    @(negedge clk_i);
  endtask

  task automatic release_input();
    s_axis_tvalid <= 1'b0;
  endtask

  // Waits for the pipeline to drain so a register write happens while idle.
  task automatic drain_pipe();
    release_input();
    while (graded_q.size() != 0) @(negedge clk_i);
    repeat (lggg_pkg::LANE_LAT + 4) @(negedge clk_i);
  endtask

  // One write strobe, then the strobe drops and a pause follows so back-to-back writes stay apart.
  task automatic write_reg(input lggg_pkg::reg_idx_e idx, input logic [47:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      lggg_pkg::REG_LIFT:     lift_regs = val;
      lggg_pkg::REG_GAMMA:    gamma_regs = val;
      lggg_pkg::REG_GAIN:     gain_regs = val;
      lggg_pkg::REG_CHANNELS: chan_count = val[2:0];
    endcase
    @(negedge clk_i);
  endtask

  function automatic pixel_t random_pixel();
    return pixel_t'($urandom);
  endfunction

  function automatic logic [15:0] random_coef(input int unsigned kind);
    case ($urandom_range(5))
      0: return 16'(lggg_pkg::COEF_ONE);
      1: return 16'($urandom_range(lggg_pkg::GAMMA_TINY_MAX));
      2: return 16'hFFFF;
      default: return kind == 0 ? 16'($urandom) : 16'($urandom_range(12000));
    endcase
  endfunction

  task automatic random_settings();
    logic [47:0] lf, gm, gn;
    for (int c = 0; c < 3; c++) begin
      lf[16*c +: 16] = ($urandom_range(3) == 0) ? 16'($urandom) :
                       16'($signed(16'($urandom_range(4096))) - 16'sd2048);
      gm[16*c +: 16] = random_coef(1);
      gn[16*c +: 16] = random_coef(1);
    end
    write_reg(lggg_pkg::REG_LIFT, lf);
    write_reg(lggg_pkg::REG_GAMMA, gm);
    write_reg(lggg_pkg::REG_GAIN, gn);
    write_reg(lggg_pkg::REG_CHANNELS, 48'($urandom_range(7)));
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    pixel_t edges[4];
    edges[0] = 32'h00000000;
    edges[1] = 32'hFFFFFFFF;
    edges[2] = 32'h80FF0001;
    edges[3] = 32'h7F01FE80;
    // Reset values: identity grade.
    foreach (edges[i]) send_pixel(edges[i]);
    drain_pipe();
    // Negative full lift, tiny gamma, zero gain on the mix, with the channel count at zero.
    write_reg(lggg_pkg::REG_LIFT, {16'h8000, 16'hF000, 16'h7FFF});
    write_reg(lggg_pkg::REG_GAMMA,
              {16'h0000, 16'(lggg_pkg::GAMMA_TINY_MAX), 16'h0800});
    write_reg(lggg_pkg::REG_GAIN, {16'hFFFF, 16'h0000, 16'h2000});
    write_reg(lggg_pkg::REG_CHANNELS, 48'd0);
    foreach (edges[i]) send_pixel(edges[i]);
    drain_pipe();
    // Huge and tiny powers: large gamma and very small gamma on dim pixels.
    write_reg(lggg_pkg::REG_CHANNELS, 48'd7);
    write_reg(lggg_pkg::REG_LIFT, 48'd0);
    write_reg(lggg_pkg::REG_GAMMA, {16'hFFFF, 16'h0005, 16'h0064});
    foreach (edges[i]) send_pixel(edges[i]);
    send_pixel(32'h00030201);
    send_pixel(32'h10FEFDFC);
    drain_pipe();
    for (int n = 1; n <= 4; n++) begin
      write_reg(lggg_pkg::REG_CHANNELS, 48'(n));
      send_pixel(32'h44332211);
      send_pixel(random_pixel());
      drain_pipe();
    end
  endtask

  task automatic test_random_phase(input int unsigned snd, input int unsigned rcv,
                                   input int unsigned beats);
    send_idle_pct = snd;
    recv_idle_pct = rcv;
    for (int i = 0; i < beats; i++) begin
      if (i % 70 == 0) begin
        drain_pipe();
        random_settings();
      end
      // Leave some stretches with no idling at all.
      if (i % 140 == 100) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (i % 140 == 0) begin
        send_idle_pct = snd;
        recv_idle_pct = rcv;
      end
      send_pixel(random_pixel());
    end
    drain_pipe();
  endtask

  // The receiver holds off long enough for the pipeline to fill and stall input.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 3 * lggg_pkg::LANE_LAT;
    for (int i = 0; i < 80; i++) send_pixel(random_pixel());
    drain_pipe();
  endtask

  initial begin
    mismatch_count = 0;
    beats_checked = 0;
    cycle_count = 0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    lift_regs = '0;
    gamma_regs = {3{16'(lggg_pkg::COEF_ONE)}};
    gain_regs = {3{16'(lggg_pkg::COEF_ONE)}};
    chan_count = 3'd3;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random_phase(6, 63, 280);
    test_random_phase(63, 6, 280);
    test_random_phase(0, 0, 230);
    test_backpressure();

    $display("Covered %0d output beats over directed edge pixels, random", beats_checked);
    $display("register settings, three idle patterns and a long output stall.");
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
